@@ rtl/etk_pkg.sv @@
`timescale 1ns / 1ps
// Package for the expression tokenizer: lexer modes, character codes,
// character class functions and the per-byte step record. No dependencies.
package etk_pkg;

    localparam int unsigned ByteW = 8;

    typedef enum logic [1:0] {
        LEX_BETWEEN = 2'd0,
        LEX_VALUE   = 2'd1,
        LEX_OPER    = 2'd2
    } t_lex_mode;

    localparam logic [ByteW-1:0] ChNul    = 8'h00;
    localparam logic [ByteW-1:0] ChTab    = 8'h09;
    localparam logic [ByteW-1:0] ChCr     = 8'h0D;
    localparam logic [ByteW-1:0] ChSpace  = 8'h20;
    localparam logic [ByteW-1:0] ChLParen = 8'h28;
    localparam logic [ByteW-1:0] ChRParen = 8'h29;
    localparam logic [ByteW-1:0] ChComma  = 8'h2C;
    localparam logic [ByteW-1:0] ChAmp    = 8'h26;
    localparam logic [ByteW-1:0] ChBar    = 8'h7C;
    localparam logic [ByteW-1:0] ChEq     = 8'h3D;
    localparam logic [ByteW-1:0] ChBang   = 8'h21;
    localparam logic [ByteW-1:0] ChLt     = 8'h3C;
    localparam logic [ByteW-1:0] ChGt     = 8'h3E;
    localparam logic [ByteW-1:0] ChPlus   = 8'h2B;
    localparam logic [ByteW-1:0] ChMinus  = 8'h2D;
    localparam logic [ByteW-1:0] ChStar   = 8'h2A;
    localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
    localparam logic [ByteW-1:0] ChPct    = 8'h25;
    localparam logic [ByteW-1:0] ChTilde  = 8'h7E;

    typedef struct packed {
        logic             has_result;
        logic [ByteW-1:0] token_byte;
        logic             starts_token;
        logic             is_operator;
        logic             stream_done;
        t_lex_mode        next_mode;
        logic [ByteW-1:0] next_pending;
    } t_lex_step;

    function automatic logic is_space_char(input logic [ByteW-1:0] c);
        return ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace);
    endfunction

    function automatic logic is_op_char(input logic [ByteW-1:0] c);
        return (c == ChLParen) || (c == ChRParen) || (c == ChComma) || (c == ChAmp)
            || (c == ChBar) || (c == ChEq) || (c == ChBang) || (c == ChLt)
            || (c == ChGt) || (c == ChPlus) || (c == ChMinus) || (c == ChStar)
            || (c == ChSlash) || (c == ChPct) || (c == ChTilde);
    endfunction

    // True when byte b completes operator a, or is a zero byte absorbed by it.
    function automatic logic joins_op(input logic [ByteW-1:0] a, input logic [ByteW-1:0] b);
        logic r;
        r = 1'b0;
        unique case (a)
            ChLParen, ChRParen, ChPlus, ChMinus, ChTilde, ChStar, ChSlash, ChPct: begin
                r = (b == ChNul);
            end
            ChAmp: begin
                r = (b == ChNul) || (b == ChAmp);
            end
            ChBar: begin
                r = (b == ChNul) || (b == ChBar);
            end
            ChLt, ChGt, ChBang, ChEq: begin
                r = (b == ChNul) || (b == ChEq);
            end
            default: begin
                r = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/etk_classify.sv @@
`timescale 1ns / 1ps
// Per-byte lexer step: classifies one character against the current mode
// and pending operator. Depends on etk_pkg.
module etk_classify (
    input  logic [etk_pkg::ByteW-1:0] i_char,
    input  logic                      i_end,
    input  etk_pkg::t_lex_mode        i_mode,
    input  logic [etk_pkg::ByteW-1:0] i_pending,
    output etk_pkg::t_lex_step        o_step
);
    import etk_pkg::*;

    logic      w_in_oper;
    logic      w_joins;
    t_lex_mode w_base_mode;

    assign w_in_oper   = (i_mode == LEX_OPER);
    assign w_joins     = w_in_oper && joins_op(i_pending, i_char);
    assign w_base_mode = (i_mode == LEX_VALUE) ? LEX_VALUE : LEX_BETWEEN;

    always_comb begin
        o_step              = '0;
        o_step.token_byte   = i_char;
        o_step.next_mode    = LEX_BETWEEN;
        o_step.next_pending = ChNul;
        priority if (i_end) begin
            o_step.has_result  = 1'b1;
            o_step.token_byte  = ChNul;
            o_step.stream_done = 1'b1;
        end else if (w_joins) begin
            o_step.has_result  = (i_char != ChNul);
            o_step.is_operator = 1'b1;
        end else if (is_space_char(i_char)) begin
            o_step.has_result = 1'b0;
        end else if (is_op_char(i_char)) begin
            o_step.has_result   = 1'b1;
            o_step.starts_token = 1'b1;
            o_step.is_operator  = 1'b1;
            o_step.next_mode    = LEX_OPER;
            o_step.next_pending = i_char;
        end else begin
            o_step.has_result   = 1'b1;
            o_step.starts_token = (w_base_mode != LEX_VALUE);
            o_step.next_mode    = LEX_VALUE;
        end
    end

endmodule

@@ rtl/expression_tokenizer.sv @@
`timescale 1ns / 1ps
// Expression tokenizer top level: lexer state, output register and skid stage.
// Depends on etk_pkg and etk_classify.
//
// The block takes one character per cycle while the skid register is empty
// and gives at most one tagged token byte per character, held in the output
// register or, while that is stalled, the skid register. Whitespace and a zero
// byte directly after an operator's first character (a comma apart) produce
// no output. A transaction with tlast set produces an end marker and returns
// the lexer to its reset state. The only loop is the update of the lexer mode
// and pending operator register; a two-entry output stage (output register
// plus skid register) keeps input flowing under a stall until the skid fills.
module expression_tokenizer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [etk_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] text_byte
    input  logic                      s_axis_tlast,  // end_of_text
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [etk_pkg::ByteW-1:0] m_axis_tdata,  // [7:0] token_byte
    output logic [1:0]                m_axis_tuser,  // [0] starts_token, [1] is_operator
    output logic                      m_axis_tlast   // stream_done
);
    import etk_pkg::*;

    localparam int unsigned OutW = ByteW + 3;

    t_lex_mode        r_mode,       n_mode;
    logic [ByteW-1:0] r_pending,    n_pending;
    logic             r_out_valid,  n_out_valid;
    logic [OutW-1:0]  r_out,        n_out;
    logic             r_skid_valid, n_skid_valid;
    logic [OutW-1:0]  r_skid,       n_skid;

    t_lex_step        w_step;
    logic             w_accept;
    logic             w_take;
    logic [OutW-1:0]  w_result;

    etk_classify u_classify (
        .i_char    (s_axis_tdata),
        .i_end     (s_axis_tlast),
        .i_mode    (r_mode),
        .i_pending (r_pending),
        .o_step    (w_step)
    );

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_take        = r_out_valid && m_axis_tready;
    assign w_result      = {w_step.stream_done, w_step.is_operator,
                            w_step.starts_token, w_step.token_byte};

    always_comb begin
        n_mode       = r_mode;
        n_pending    = r_pending;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_accept) begin
            n_mode    = w_step.next_mode;
            n_pending = w_step.next_pending;
        end
        if (w_take) begin
            n_out_valid  = r_skid_valid;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end
        if (w_accept && w_step.has_result) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out       = w_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= LEX_BETWEEN;
            r_pending    <= ChNul;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_pending    <= n_pending;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out[ByteW-1:0];
    assign m_axis_tuser  = r_out[ByteW+1:ByteW];
    assign m_axis_tlast  = r_out[ByteW+2];

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds data while output register is empty");

    a_end_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> (r_mode == LEX_BETWEEN && r_pending == ChNul))
        else $error("lexer state not cleared after end of text");

    a_pending_is_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == LEX_OPER) |-> is_op_char(r_pending))
        else $error("pending operator is not an operator character");

    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == ChNul && m_axis_tuser == 2'b00))
        else $error("end marker carries token data");

    a_second_char_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast && !m_axis_tuser[1]) |-> !is_op_char(m_axis_tdata))
        else $error("operator character emitted as a value byte");

endmodule

@@ tb/expression_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for expression_tokenizer: directed table, then random
// expression text, with a local predictor and random stalls on both streams.
// Depends on etk_pkg and the tokenizer RTL.
module expression_tokenizer_tb;

    import etk_pkg::*;

    localparam int unsigned RandChars = 450;
    localparam int unsigned HoldCycles = 80;
    localparam int unsigned DirRows = 28;

    typedef struct packed {
        logic [ByteW-1:0] token_byte;
        logic             starts_token;
        logic             is_operator;
        logic             stream_done;
    } t_tok_rec;

    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_NONE    = 2'd1,
        ROW_RESULT  = 2'd2
    } t_row_kind;

    typedef struct packed {
        logic [ByteW-1:0] text;
        logic             eot;
        t_row_kind        kind;
        t_tok_rec         want;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [ByteW-1:0] s_axis_tdata;   // [7:0] text_byte
    logic             s_axis_tlast;   // end_of_text
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [ByteW-1:0] m_axis_tdata;   // [7:0] token_byte
    logic [1:0]       m_axis_tuser;   // [0] starts_token, [1] is_operator
    logic             m_axis_tlast;   // stream_done

    t_tok_rec  token_fifo [$];
    t_lex_mode lex_state;
    logic [ByteW-1:0] op_held;
    int unsigned errors;
    int unsigned chars_sent;
    int unsigned burst_left;
    bit          hold_req;

    t_stim_row dir_rows [DirRows] = '{
        '{ChNul,    1'b0, ROW_RESULT,  '{ChNul,    1'b1, 1'b0, 1'b0}},
        '{8'hFF,    1'b0, ROW_RESULT,  '{8'hFF,    1'b0, 1'b0, 1'b0}},
        '{ChSpace,  1'b0, ROW_NONE,    '0},
        '{ChAmp,    1'b0, ROW_RESULT,  '{ChAmp,    1'b1, 1'b1, 1'b0}},
        '{ChAmp,    1'b0, ROW_RESULT,  '{ChAmp,    1'b0, 1'b1, 1'b0}},
        '{ChBar,    1'b0, ROW_PREDICT, '0},
        '{ChBar,    1'b0, ROW_PREDICT, '0},
        '{ChLt,     1'b0, ROW_PREDICT, '0},
        '{ChEq,     1'b0, ROW_PREDICT, '0},
        '{ChGt,     1'b0, ROW_PREDICT, '0},
        '{ChEq,     1'b0, ROW_PREDICT, '0},
        '{ChBang,   1'b0, ROW_PREDICT, '0},
        '{ChEq,     1'b0, ROW_PREDICT, '0},
        '{ChEq,     1'b0, ROW_PREDICT, '0},
        '{ChEq,     1'b0, ROW_PREDICT, '0},
        '{ChLParen, 1'b0, ROW_PREDICT, '0},
        '{ChNul,    1'b0, ROW_NONE,    '0},
        '{ChComma,  1'b0, ROW_PREDICT, '0},
        '{ChNul,    1'b0, ROW_PREDICT, '0},
        '{ChRParen, 1'b0, ROW_PREDICT, '0},
        '{8'h41,    1'b0, ROW_PREDICT, '0},
        '{ChTab,    1'b0, ROW_NONE,    '0},
        '{ChStar,   1'b0, ROW_PREDICT, '0},
        '{ChSlash,  1'b0, ROW_PREDICT, '0},
        '{ChPct,    1'b0, ROW_PREDICT, '0},
        '{ChPlus,   1'b0, ROW_PREDICT, '0},
        '{ChCr,     1'b0, ROW_NONE,    '0},
        '{8'hFF,    1'b1, ROW_RESULT,  '{ChNul,    1'b0, 1'b0, 1'b1}}
    };

    expression_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return (c >= ChTab && c <= ChCr) || c == ChSpace;
    endfunction

    function automatic logic is_oper(input logic [ByteW-1:0] c);
        case (c)
            ChLParen, ChRParen, ChComma, ChAmp, ChBar, ChEq, ChBang, ChLt,
            ChGt, ChPlus, ChMinus, ChStar, ChSlash, ChPct, ChTilde: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Second character that turns an operator into a two-character one, or zero.
    function automatic logic [ByteW-1:0] pair_mate(input logic [ByteW-1:0] c);
        case (c)
            ChAmp: return ChAmp;
            ChBar: return ChBar;
            ChLt, ChGt, ChBang, ChEq: return ChEq;
            default: return ChNul;
        endcase
    endfunction

    function automatic logic op_takes(input logic [ByteW-1:0] a, input logic [ByteW-1:0] b);
        return (b == ChNul && a != ChComma) || (pair_mate(a) != ChNul && b == pair_mate(a));
    endfunction

    function automatic logic [ByteW-1:0] op_pick(input int unsigned idx);
        case (idx)
            0: return ChLParen;
            1: return ChRParen;
            2: return ChComma;
            3: return ChAmp;
            4: return ChBar;
            5: return ChEq;
            6: return ChBang;
            7: return ChLt;
            8: return ChGt;
            9: return ChPlus;
            10: return ChMinus;
            11: return ChStar;
            12: return ChSlash;
            13: return ChPct;
            default: return ChTilde;
        endcase
    endfunction

    function automatic logic [ByteW-1:0] value_char();
        logic [ByteW-1:0] c;
        do begin
            c = ByteW'($urandom_range(0, 255));
        end while (is_blank(c) || is_oper(c));
        return c;
    endfunction

    task automatic lex_step(input logic [ByteW-1:0] c, input logic eot,
                            output logic has, output t_tok_rec r);
        logic done_pair;
        r = '0;
        has = 1'b0;
        done_pair = 1'b0;
        if (eot) begin
            r.stream_done = 1'b1;
            has = 1'b1;
            lex_state = LEX_BETWEEN;
            op_held = ChNul;
        end else begin
            if (lex_state == LEX_OPER) begin
                done_pair = op_takes(op_held, c);
                lex_state = LEX_BETWEEN;
                op_held = ChNul;
                if (done_pair && c != ChNul) begin
                    has = 1'b1;
                    r = '{c, 1'b0, 1'b1, 1'b0};
                end
            end
            if (!done_pair) begin
                if (is_blank(c)) begin
                    lex_state = LEX_BETWEEN;
                end else if (is_oper(c)) begin
                    lex_state = LEX_OPER;
                    op_held = c;
                    has = 1'b1;
                    r = '{c, 1'b1, 1'b1, 1'b0};
                end else begin
                    has = 1'b1;
                    r = '{c, lex_state != LEX_VALUE, 1'b0, 1'b0};
                    lex_state = LEX_VALUE;
                end
            end
        end
    endtask

    task automatic put_char(input logic [ByteW-1:0] c, input logic eot,
                            input t_row_kind kind, input t_tok_rec want);
        logic has;
        t_tok_rec r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= eot;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        lex_step(c, eot, has, r);
        if (kind == ROW_RESULT) begin
            token_fifo.push_back(want);
        end else if (kind == ROW_PREDICT && has) begin
            token_fifo.push_back(r);
        end
        chars_sent++;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= ByteW'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_tokens();
        s_axis_tvalid <= 1'b0;
        while (token_fifo.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [ByteW-1:0] exp_v,
                               input logic [ByteW-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : token_check
        t_tok_rec want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (token_fifo.size() == 0) begin
                $display({"%0t: unexpected transaction, expected none, ",
                          "actual tdata %h tuser %b tlast %b"},
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                want = token_fifo.pop_front();
                check_field("token_byte", want.token_byte, m_axis_tdata);
                check_field("starts_token", ByteW'(want.starts_token),
                            ByteW'(m_axis_tuser[0]));
                check_field("is_operator", ByteW'(want.is_operator),
                            ByteW'(m_axis_tuser[1]));
                check_field("stream_done", ByteW'(want.stream_done),
                            ByteW'(m_axis_tlast));
            end
        end
    end

    // Receiver: rotating stall patterns, with a long hold-off on request.
    initial begin : token_sink
        logic [15:0] stall_pat;
        int unsigned pat_left;
        m_axis_tready = 1'b0;
        pat_left = 0;
        stall_pat = '1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                if (pat_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: stall_pat = 16'hFFFF;
                        1: stall_pat = 16'($urandom);
                        2: stall_pat = 16'h0F0F;
                        default: stall_pat = 16'h8421;
                    endcase
                    pat_left = 64;
                end
                m_axis_tready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
                pat_left--;
            end
        end
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : text_source
        logic [ByteW-1:0] c;
        int unsigned pick;
        int unsigned n;
        bit held;
        bit drained;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        hold_req = 1'b0;
        errors = 0;
        chars_sent = 0;
        burst_left = 8;
        lex_state = LEX_BETWEEN;
        op_held = ChNul;
        held = 1'b0;
        drained = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DirRows; i++) begin
            put_char(dir_rows[i].text, dir_rows[i].eot, dir_rows[i].kind, dir_rows[i].want);
        end

        chars_sent = 0;
        while (chars_sent < RandChars) begin
            if (!held && chars_sent >= 150) begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (!drained && chars_sent >= 300) begin
                drained = 1'b1;
                drain_tokens();
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 1)) begin
                        put_char(ByteW'(8'h61 + $urandom_range(0, 25)), 1'b0,
                                 ROW_PREDICT, '0);
                    end else begin
                        put_char(value_char(), 1'b0, ROW_PREDICT, '0);
                    end
                end
            end else if (pick < 62) begin
                c = op_pick($urandom_range(0, 14));
                put_char(c, 1'b0, ROW_PREDICT, '0);
                n = $urandom_range(0, 9);
                if (n < 5 && pair_mate(c) != ChNul) begin
                    put_char(pair_mate(c), 1'b0, ROW_PREDICT, '0);
                end else if (n == 5) begin
                    put_char(ChNul, 1'b0, ROW_PREDICT, '0);
                end
            end else if (pick < 76) begin
                repeat ($urandom_range(1, 2)) begin
                    n = $urandom_range(0, 5);
                    put_char((n == 5) ? ChSpace : ByteW'(ChTab + n), 1'b0, ROW_PREDICT, '0);
                end
            end else if (pick < 95) begin
                put_char(ByteW'($urandom_range(0, 255)), 1'b0, ROW_PREDICT, '0);
            end else begin
                put_char(ByteW'($urandom_range(0, 255)), 1'b1, ROW_PREDICT, '0);
            end
        end
        put_char(ByteW'($urandom_range(0, 255)), 1'b1, ROW_PREDICT, '0);

        drain_tokens();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
